// ===== rtl/core/bra_pkg.sv =====
// Shared constants, types and a helper function for the boolean relation analyser.
// No dependencies; imported by every module of the block but bra_ram.
`default_nettype none
package bra_pkg;

  localparam int RowW           = 16;
  localparam int SizeW          = 5;
  localparam int PathW          = 8;
  localparam int ElemW          = 16;
  localparam int DegW           = 5;
  localparam int FlagW          = 7;
  localparam int IdxOutW        = 4;
  localparam int CfgIdxW        = 2;
  localparam int CfgDataW       = 8;
  localparam int MaxElementsDef = 16;

  // Config register indexes
  localparam logic [CfgIdxW-1:0] CFG_SIZE = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_PATH = 2'd1;

  // Property flag bit positions
  localparam int FLAG_REFL  = 0;
  localparam int FLAG_IRREF = 1;
  localparam int FLAG_SYM   = 2;
  localparam int FLAG_ANTI  = 3;
  localparam int FLAG_ASYM  = 4;
  localparam int FLAG_TRANS = 5;
  localparam int FLAG_EQUIV = 6;

  // Load memory word: relation row, second row, element value
  localparam int M1W     = 3 * RowW;
  localparam int M1_A    = 2 * RowW;
  localparam int M1_B    = RowW;
  localparam int M1_E    = 0;
  // Work memory word: closure, power, composition, transpose
  localparam int M2W     = 4 * RowW;
  localparam int M2_CLO  = 3 * RowW;
  localparam int M2_POW  = 2 * RowW;
  localparam int M2_COMP = RowW;
  localparam int M2_TR   = 0;

  typedef struct packed {
    logic               vld;
    logic               last;
    logic [IdxOutW-1:0] idx;
  } emit_t;

  function automatic logic [DegW-1:0] popcount16(input logic [RowW-1:0] v);
    logic [2:0] nib [4];
    for (int n = 0; n < 4; n++) begin
      nib[n] = 3'(v[4*n]) + 3'(v[4*n+1]) + 3'(v[4*n+2]) + 3'(v[4*n+3]);
    end
    return (DegW'(nib[0]) + DegW'(nib[1])) + (DegW'(nib[2]) + DegW'(nib[3]));
  endfunction

endpackage
`default_nettype wire

// ===== rtl/core/bra_ram.sv =====
// Generic simple dual-port RAM: one write port, one registered read port (old data on clash).
// No dependencies.
`default_nettype none
module bra_ram #(
  parameter int Width = 16,
  parameter int Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule
`default_nettype wire

// ===== rtl/core/bra_engine.sv =====
// Sequencer and datapath: row load, product passes, Warshall passes and row read-out.
// Depends on bra_pkg; drives the two bra_ram instances held in the top level.
`default_nettype none
module bra_engine import bra_pkg::*; #(
  parameter int MaxElements = MaxElementsDef
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     start_i,
  output logic                          busy_o,
  input  wire logic [RowW-1:0]          row_a_i,
  input  wire logic [RowW-1:0]          row_b_i,
  input  wire logic [ElemW-1:0]         elem_i,
  input  wire logic [SizeW-1:0]         size_i,
  input  wire logic [PathW-1:0]         path_i,
  output logic                          m1_we_o,
  output logic [$clog2((MaxElements < RowW) ? MaxElements : RowW)-1:0] m1_waddr_o,
  output logic [M1W-1:0]                m1_wdata_o,
  output logic [$clog2((MaxElements < RowW) ? MaxElements : RowW)-1:0] m1_raddr_o,
  input  wire logic [M1W-1:0]           m1_rdata_i,
  output logic                          m2_we_o,
  output logic [$clog2((MaxElements < RowW) ? MaxElements : RowW)-1:0] m2_waddr_o,
  output logic [M2W-1:0]                m2_wdata_o,
  output logic [$clog2((MaxElements < RowW) ? MaxElements : RowW)-1:0] m2_raddr_o,
  input  wire logic [M2W-1:0]           m2_rdata_i,
  output emit_t                         emit_o,
  output logic [FlagW-1:0]              flags_o,
  output logic [RowW-1:0]               mask_o
);

  localparam int RowCap = (MaxElements < RowW) ? MaxElements : RowW;
  localparam int AddrW  = $clog2(RowCap);
  localparam int CntW   = $clog2(RowCap + 1);

  typedef enum logic [7:0] {
    S_LOAD   = 8'b0000_0001,
    S_PHEAD  = 8'b0000_0010,
    S_PLATCH = 8'b0000_0100,
    S_PSWEEP = 8'b0000_1000,
    S_WHEAD  = 8'b0001_0000,
    S_WLATCH = 8'b0010_0000,
    S_WSWEEP = 8'b0100_0000,
    S_EMIT   = 8'b1000_0000
  } state_e;

  state_e           state_q, state_d;
  logic [CntW-1:0]  loaded_q, loaded_d;
  logic [AddrW-1:0] i_q, i_d, kd_q, kd_d;
  logic [PathW-1:0] pw_q, pw_d;
  logic             first_q, first_d;
  emit_t            emit_q, emit_d;

  // payload registers
  logic [AddrW-1:0] nm1_q, nm1_d;
  logic [RowW-1:0]  mask_q, mask_d;
  logic [RowW-1:0]  ra_q, ra_d, rp_q, rp_d, rk_q, rk_d;
  logic [RowW-1:0]  aa_q, aa_d, ab_q, ab_d, ap_q, ap_d, tr_q, tr_d;
  logic [M2W-1:0]   hold_q, hold_d;
  logic             refl_q, refl_d, irr_q, irr_d, sym_q, sym_d;
  logic             anti_q, anti_d, tro_q, tro_d;

  logic [CntW-1:0]  n_cur, cnt_next;
  logic [RowW-1:0]  mask_cur, row_a, row_b, oh_kd, oh_i, clo_row;
  logic [PathW-1:0] pw_next;

  always_comb begin
    if (size_i == '0) begin
      n_cur = CntW'(1);
    end else if (size_i > SizeW'(RowCap)) begin
      n_cur = CntW'(RowCap);
    end else begin
      n_cur = CntW'(size_i);
    end
    for (int j = 0; j < RowW; j++) begin
      mask_cur[j] = (SizeW'(j) < SizeW'(n_cur));
    end
  end

  assign cnt_next = loaded_q + CntW'(1);
  assign row_a    = m1_rdata_i[M1_A +: RowW] & mask_q;
  assign row_b    = m1_rdata_i[M1_B +: RowW] & mask_q;
  assign oh_kd    = RowW'(1) << kd_q;
  assign oh_i     = RowW'(1) << i_q;
  assign clo_row  = m2_rdata_i[M2_CLO +: RowW];
  assign pw_next  = (pw_q != '0) ? pw_q - PathW'(1) : '0;

  always_comb begin
    state_d  = state_q;
    loaded_d = loaded_q;
    i_d      = i_q;
    kd_d     = kd_q;
    pw_d     = pw_q;
    first_d  = first_q;
    emit_d   = '0;
    nm1_d    = nm1_q;
    mask_d   = mask_q;
    ra_d     = ra_q;
    rp_d     = rp_q;
    rk_d     = rk_q;
    hold_d   = hold_q;
    aa_d     = aa_q;
    ab_d     = ab_q;
    ap_d     = ap_q;
    tr_d     = tr_q;
    refl_d   = refl_q;
    irr_d    = irr_q;
    sym_d    = sym_q;
    anti_d   = anti_q;
    tro_d    = tro_q;

    m1_we_o    = 1'b0;
    m1_waddr_o = loaded_q[AddrW-1:0];
    m1_wdata_o = {row_a_i, row_b_i, elem_i};
    m1_raddr_o = i_q;
    m2_we_o    = 1'b0;
    m2_waddr_o = loaded_q[AddrW-1:0];
    m2_wdata_o = {row_a_i, row_a_i, {(2*RowW){1'b0}}};
    m2_raddr_o = i_q;

    unique case (state_q)
      S_LOAD: begin
        if (start_i) begin
          m1_we_o = 1'b1;
          m2_we_o = 1'b1;
          if (cnt_next >= n_cur) begin
            loaded_d = '0;
            nm1_d    = AddrW'(n_cur - CntW'(1));
            mask_d   = mask_cur;
            pw_d     = (path_i <= PathW'(1)) ? '0 : path_i - PathW'(1);
            first_d  = 1'b1;
            i_d      = '0;
            refl_d   = 1'b1;
            irr_d    = 1'b1;
            sym_d    = 1'b1;
            anti_d   = 1'b1;
            tro_d    = 1'b1;
            state_d  = S_PHEAD;
          end else begin
            loaded_d = cnt_next;
          end
        end
      end
      S_PHEAD: begin
        state_d = S_PLATCH;
      end
      S_PLATCH: begin
        ra_d       = row_a;
        rp_d       = m2_rdata_i[M2_POW +: RowW];
        hold_d     = m2_rdata_i;
        aa_d       = '0;
        ab_d       = '0;
        ap_d       = '0;
        tr_d       = '0;
        m1_raddr_o = '0;
        kd_d       = '0;
        state_d    = S_PSWEEP;
      end
      S_PSWEEP: begin
        aa_d       = aa_q | (ra_q[kd_q] ? row_a : '0);
        ab_d       = ab_q | (ra_q[kd_q] ? row_b : '0);
        ap_d       = ap_q | (rp_q[kd_q] ? row_a : '0);
        tr_d       = tr_q | (row_a[i_q] ? oh_kd : '0);
        m1_raddr_o = kd_q + AddrW'(1);
        kd_d       = kd_q + AddrW'(1);
        if (kd_q == nm1_q) begin
          m2_we_o    = 1'b1;
          m2_waddr_o = i_q;
          m2_wdata_o = {hold_q[M2_CLO +: RowW],
                        (pw_q != '0) ? ap_d : hold_q[M2_POW +: RowW],
                        first_q ? ab_d : hold_q[M2_COMP +: RowW],
                        first_q ? tr_d : hold_q[M2_TR +: RowW]};
          if (first_q) begin
            refl_d = refl_q & ra_q[i_q];
            irr_d  = irr_q & ~ra_q[i_q];
            sym_d  = sym_q & (ra_q == tr_d);
            anti_d = anti_q & ((ra_q & tr_d & ~oh_i) == '0);
            tro_d  = tro_q & ((aa_d & ~ra_q) == '0);
          end
          if (i_q == nm1_q) begin
            i_d     = '0;
            first_d = 1'b0;
            pw_d    = pw_next;
            state_d = (pw_next != '0) ? S_PHEAD : S_WHEAD;
          end else begin
            i_d     = i_q + AddrW'(1);
            state_d = S_PHEAD;
          end
        end
      end
      S_WHEAD: begin
        state_d = S_WLATCH;
      end
      S_WLATCH: begin
        rk_d       = clo_row;
        m2_raddr_o = '0;
        kd_d       = '0;
        state_d    = S_WSWEEP;
      end
      S_WSWEEP: begin
        m2_we_o    = 1'b1;
        m2_waddr_o = kd_q;
        m2_wdata_o = {clo_row[i_q] ? (clo_row | rk_q) : clo_row,
                      m2_rdata_i[M2_CLO-1:0]};
        m2_raddr_o = kd_q + AddrW'(1);
        kd_d       = kd_q + AddrW'(1);
        if (kd_q == nm1_q) begin
          if (i_q == nm1_q) begin
            i_d     = '0;
            state_d = S_EMIT;
          end else begin
            i_d     = i_q + AddrW'(1);
            state_d = S_WHEAD;
          end
        end
      end
      S_EMIT: begin
        emit_d.vld  = 1'b1;
        emit_d.last = (i_q == nm1_q);
        emit_d.idx  = IdxOutW'(i_q);
        i_d         = i_q + AddrW'(1);
        if (i_q == nm1_q) begin
          i_d     = '0;
          state_d = S_LOAD;
        end
      end
      default: begin
        state_d = S_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_LOAD;
      loaded_q <= '0;
      i_q      <= '0;
      kd_q     <= '0;
      pw_q     <= '0;
      first_q  <= 1'b0;
      emit_q   <= '0;
    end else begin
      state_q  <= state_d;
      loaded_q <= loaded_d;
      i_q      <= i_d;
      kd_q     <= kd_d;
      pw_q     <= pw_d;
      first_q  <= first_d;
      emit_q   <= emit_d;
    end
  end

  always_ff @(posedge clk_i) begin
    nm1_q  <= nm1_d;
    mask_q <= mask_d;
    ra_q   <= ra_d;
    rp_q   <= rp_d;
    rk_q   <= rk_d;
    hold_q <= hold_d;
    aa_q   <= aa_d;
    ab_q   <= ab_d;
    ap_q   <= ap_d;
    tr_q   <= tr_d;
    refl_q <= refl_d;
    irr_q  <= irr_d;
    sym_q  <= sym_d;
    anti_q <= anti_d;
    tro_q  <= tro_d;
  end

  assign busy_o = (state_q != S_LOAD);
  assign emit_o = emit_q;
  assign mask_o = mask_q;

  always_comb begin
    flags_o             = '0;
    flags_o[FLAG_REFL]  = refl_q;
    flags_o[FLAG_IRREF] = irr_q;
    flags_o[FLAG_SYM]   = sym_q;
    flags_o[FLAG_ANTI]  = anti_q;
    flags_o[FLAG_ASYM]  = irr_q & anti_q;
    flags_o[FLAG_TRANS] = tro_q;
    flags_o[FLAG_EQUIV] = refl_q & sym_q & tro_q;
  end

endmodule
`default_nettype wire

// ===== rtl/core/bra_emit.sv =====
// Result formatter: turns one row read from both memories into a registered result beat.
// Depends on bra_pkg.
`default_nettype none
module bra_emit import bra_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire emit_t             emit_i,
  input  wire logic [M1W-1:0]    m1_rdata_i,
  input  wire logic [M2W-1:0]    m2_rdata_i,
  input  wire logic [RowW-1:0]   mask_i,
  input  wire logic [FlagW-1:0]  flags_i,
  output logic                   strobe_o,
  output logic [IdxOutW-1:0]     row_index_o,
  output logic signed [ElemW-1:0] element_out_o,
  output logic [DegW-1:0]        out_degree_o,
  output logic [DegW-1:0]        in_degree_o,
  output logic [RowW-1:0]        transitive_row_o,
  output logic [RowW-1:0]        reflexive_row_o,
  output logic [RowW-1:0]        symmetric_row_o,
  output logic [RowW-1:0]        power_row_o,
  output logic [RowW-1:0]        composition_row_o,
  output logic [FlagW-1:0]       property_flags_o,
  output logic                   last_row_o
);

  logic [RowW-1:0] a_row, t_row;

  assign a_row = m1_rdata_i[M1_A +: RowW] & mask_i;
  assign t_row = m2_rdata_i[M2_TR +: RowW];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      strobe_o <= 1'b0;
    end else begin
      strobe_o <= emit_i.vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit_i.vld) begin
      row_index_o       <= emit_i.idx;
      element_out_o     <= m1_rdata_i[M1_E +: ElemW];
      out_degree_o      <= popcount16(a_row);
      in_degree_o       <= popcount16(t_row);
      transitive_row_o  <= m2_rdata_i[M2_CLO +: RowW] & mask_i;
      reflexive_row_o   <= a_row | (RowW'(1) << emit_i.idx);
      symmetric_row_o   <= a_row | t_row;
      power_row_o       <= m2_rdata_i[M2_POW +: RowW] & mask_i;
      composition_row_o <= m2_rdata_i[M2_COMP +: RowW];
      property_flags_o  <= flags_i;
      last_row_o        <= emit_i.last;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/boolean_relation_analyzer_top.sv =====
// Top level of the boolean relation analyser: config registers, two row memories,
// sequencer and result formatter. Depends on bra_pkg, bra_ram, bra_engine, bra_emit.
//
// Use:
//  - Input: one beat per matrix row, taken on a clock edge with start high and busy
//    low: row_a_i (relation row), row_b_i (second relation row), element_value_i.
//    While rows load, busy stays low, so rows may arrive back to back.
//  - The beat that brings the row count up to the effective size N starts the
//    analysis; busy stays high until the last row is read out, before its result.
//  - Config: cfg_we_i with cfg_index_i (0 size, 1 path length, else dropped) and
//    cfg_data_i on the clock edge; write only between matrices, not enforced.
//  - Results: N beats, one per row in order, each shown for one cycle with strobe_o;
//    last_row_o marks row N-1. The receiver cannot stall; beats come back to back.
//  - Order after the last row (N rows, P = path length): one combined product
//    pass plus max(0, P-2) power passes, then N Warshall pivots, then N row
//    read-outs; each result passes the emit and formatter registers. A sweep walks
//    one memory a row per cycle on its one read port after head and latch states.
//  - Reset clears the sequencer and row count; memory contents stay undefined and
//    no clearing pass is needed, as every row read was written in the same load.
`default_nettype none
module boolean_relation_analyzer_top import bra_pkg::*; #(
  parameter int MaxElements = MaxElementsDef
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                start,
  output logic                     busy,
  input  wire logic                cfg_we_i,
  input  wire logic [CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [CfgDataW-1:0] cfg_data_i,
  input  wire logic [RowW-1:0]     row_a_i,
  input  wire logic [RowW-1:0]     row_b_i,
  input  wire logic signed [ElemW-1:0] element_value_i,
  output logic                     strobe_o,
  output logic [IdxOutW-1:0]       row_index_o,
  output logic signed [ElemW-1:0]  element_out_o,
  output logic [DegW-1:0]          out_degree_o,
  output logic [DegW-1:0]          in_degree_o,
  output logic [RowW-1:0]          transitive_row_o,
  output logic [RowW-1:0]          reflexive_row_o,
  output logic [RowW-1:0]          symmetric_row_o,
  output logic [RowW-1:0]          power_row_o,
  output logic [RowW-1:0]          composition_row_o,
  output logic [FlagW-1:0]         property_flags_o,
  output logic                     last_row_o
);

  localparam int RowCap = (MaxElements < RowW) ? MaxElements : RowW;
  localparam int AddrW  = $clog2(RowCap);

  // config registers
  logic [SizeW-1:0] size_q;
  logic [PathW-1:0] path_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_q <= SizeW'(16);
      path_q <= PathW'(1);
    end else if (cfg_we_i) begin
      if (cfg_index_i == CFG_SIZE) begin
        size_q <= cfg_data_i[SizeW-1:0];
      end
      if (cfg_index_i == CFG_PATH) begin
        path_q <= cfg_data_i[PathW-1:0];
      end
    end
  end

  // memory ports
  logic             m1_we, m2_we;
  logic [AddrW-1:0] m1_waddr, m1_raddr, m2_waddr, m2_raddr;
  logic [M1W-1:0]   m1_wdata, m1_rdata;
  logic [M2W-1:0]   m2_wdata, m2_rdata;
  emit_t            emit;
  logic [FlagW-1:0] flags;
  logic [RowW-1:0]  mask;

  // load memory: relation row, second row, element value
  bra_ram #(.Width(M1W), .Depth(RowCap)) u_load_ram (
    .clk_i   (clk_i),
    .we_i    (m1_we),
    .waddr_i (m1_waddr),
    .wdata_i (m1_wdata),
    .raddr_i (m1_raddr),
    .rdata_o (m1_rdata)
  );

  // work memory: closure, power, composition, transpose
  bra_ram #(.Width(M2W), .Depth(RowCap)) u_work_ram (
    .clk_i   (clk_i),
    .we_i    (m2_we),
    .waddr_i (m2_waddr),
    .wdata_i (m2_wdata),
    .raddr_i (m2_raddr),
    .rdata_o (m2_rdata)
  );

  bra_engine #(.MaxElements(MaxElements)) u_engine (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start),
    .busy_o     (busy),
    .row_a_i    (row_a_i),
    .row_b_i    (row_b_i),
    .elem_i     (element_value_i),
    .size_i     (size_q),
    .path_i     (path_q),
    .m1_we_o    (m1_we),
    .m1_waddr_o (m1_waddr),
    .m1_wdata_o (m1_wdata),
    .m1_raddr_o (m1_raddr),
    .m1_rdata_i (m1_rdata),
    .m2_we_o    (m2_we),
    .m2_waddr_o (m2_waddr),
    .m2_wdata_o (m2_wdata),
    .m2_raddr_o (m2_raddr),
    .m2_rdata_i (m2_rdata),
    .emit_o     (emit),
    .flags_o    (flags),
    .mask_o     (mask)
  );

  bra_emit u_emit (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .emit_i            (emit),
    .m1_rdata_i        (m1_rdata),
    .m2_rdata_i        (m2_rdata),
    .mask_i            (mask),
    .flags_i           (flags),
    .strobe_o          (strobe_o),
    .row_index_o       (row_index_o),
    .element_out_o     (element_out_o),
    .out_degree_o      (out_degree_o),
    .in_degree_o       (in_degree_o),
    .transitive_row_o  (transitive_row_o),
    .reflexive_row_o   (reflexive_row_o),
    .symmetric_row_o   (symmetric_row_o),
    .power_row_o       (power_row_o),
    .composition_row_o (composition_row_o),
    .property_flags_o  (property_flags_o),
    .last_row_o        (last_row_o)
  );

`ifndef SYNTH
  // result beats of one matrix come in an unbroken run of rising row indexes
  a_rows_in_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_o && !last_row_o |=>
      strobe_o && (row_index_o == IdxOutW'($past(row_index_o) + IdxOutW'(1))))
    else $error("result rows out of order");

  // nothing follows the last row in the next cycle
  a_gap_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_o && last_row_o |=> !strobe_o)
    else $error("result beat right after last row");

  // derived flags agree with the flags they derive from
  a_flag_consistency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_o |->
      (!property_flags_o[FLAG_EQUIV] || (property_flags_o[FLAG_REFL] &&
        property_flags_o[FLAG_SYM] && property_flags_o[FLAG_TRANS])) &&
      (!property_flags_o[FLAG_ASYM] || (property_flags_o[FLAG_IRREF] &&
        property_flags_o[FLAG_ANTI])))
    else $error("inconsistent property flags");
`endif

endmodule
`default_nettype wire
